@@ sv/lgff_pkg.sv @@
package lgff_pkg;

  // Field widths fixed by the interface
  localparam int unsigned CmdWidth    = 2;
  localparam int unsigned ChanWidth   = 4;
  localparam int unsigned WordWidth   = 12;
  localparam int unsigned KindWidth   = 2;
  localparam int unsigned PeriodWidth = 10;

  // Full-scale duty; the store keeps FullScale minus duty
  localparam logic [WordWidth-1:0]   FullScale   = 12'd4095;
  localparam logic [PeriodWidth-1:0] PeriodReset = 10'd20;

  typedef enum logic [CmdWidth-1:0] {
    CMD_SET  = 2'd0,
    CMD_GET  = 2'd1,
    CMD_TICK = 2'd2
  } cmd_e;

  typedef enum logic [KindWidth-1:0] {
    KIND_READ  = 2'd0,
    KIND_BLANK = 2'd1,
    KIND_GREY  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GET,
    ST_BLANK,
    ST_STREAM
  } state_e;

  // Store access strobes from the sequencer
  typedef struct packed {
    logic we;
    logic re;
  } store_ctl_t;

  // Result word request from the sequencer to the output register
  typedef struct packed {
    logic  load;
    kind_e kind;
    logic  blank;
    logic  last;
    logic  zero_reply;
  } emit_t;

endpackage

@@ sv/lgff_ram.sv @@
module lgff_ram #(
  parameter int unsigned Width = 12,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/lgff_store.sv @@
module lgff_store #(
  parameter int unsigned NUM_CHANNELS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lgff_pkg::store_ctl_t            ctl_i,
  input  logic [$clog2(NUM_CHANNELS)-1:0] addr_i,
  input  logic [lgff_pkg::WordWidth-1:0]  wdata_i,
  output logic [lgff_pkg::WordWidth-1:0]  rdata_o
);
  import lgff_pkg::*;

  logic [NUM_CHANNELS-1:0] valid_q;
  logic                    rvalid_q;
  logic [WordWidth-1:0]    ram_rdata;

  lgff_ram #(
    .Width(WordWidth),
    .Depth(NUM_CHANNELS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ctl_i.we),
    .waddr_i(addr_i),
    .wdata_i(wdata_i),
    .re_i   (ctl_i.re),
    .raddr_i(addr_i),
    .rdata_o(ram_rdata)
  );

  // Mark written entries; an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (ctl_i.we) begin
        valid_q[addr_i] <= 1'b1;
      end
      if (ctl_i.re) begin
        rvalid_q <= valid_q[addr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? ram_rdata : '0;

endmodule

@@ sv/lgff_ctrl.sv @@
module lgff_ctrl #(
  parameter int unsigned NUM_CHANNELS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic [lgff_pkg::CmdWidth-1:0]    cmd_i,
  input  logic [lgff_pkg::ChanWidth-1:0]   channel_i,
  input  logic [lgff_pkg::PeriodWidth-1:0] frame_period_i,
  input  logic                             out_free_i,
  output logic                             in_ready_o,
  output lgff_pkg::store_ctl_t             store_ctl_o,
  output logic [$clog2(NUM_CHANNELS)-1:0]  addr_o,
  output lgff_pkg::emit_t                  emit_o
);
  import lgff_pkg::*;

  localparam int unsigned AddrWidth = $clog2(NUM_CHANNELS);
  localparam logic [AddrWidth-1:0] LastIdx = AddrWidth'(NUM_CHANNELS - 1);

  state_e                 state_q, state_d;
  logic [PeriodWidth-1:0] tick_q, tick_d;
  logic                   dirty_q, dirty_d;
  logic [AddrWidth-1:0]   idx_q, idx_d;
  logic                   first_q, first_d;
  logic                   oob_q, oob_d;

  logic                   accept;
  logic                   in_range;
  logic                   boundary;
  logic [PeriodWidth-1:0] period;
  logic [PeriodWidth-1:0] tick_inc;
  cmd_e                   cmd;

  assign cmd      = cmd_e'(cmd_i);
  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign in_range = 32'(channel_i) < NUM_CHANNELS;
  assign boundary = (tick_q == '0);
  assign in_ready_o = (state_q == ST_IDLE);

  // Frame counter: a zero period behaves as one
  assign period   = (frame_period_i == '0) ? PeriodWidth'(1) : frame_period_i;
  assign tick_inc = tick_q + 1'b1;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_GET:  state_d = ST_GET;
            CMD_TICK: begin
              if (boundary) begin
                state_d = dirty_q ? ST_STREAM : ST_BLANK;
              end
            end
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_GET, ST_BLANK: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_STREAM: begin
        if (out_free_i && (idx_q == '0)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath register updates
  always_comb begin
    store_ctl_o = '0;
    addr_o      = idx_q;
    emit_o      = '0;
    emit_o.kind = KIND_READ;
    tick_d      = tick_q;
    dirty_d     = dirty_q;
    idx_d       = idx_q;
    first_d     = first_q;
    oob_d       = oob_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_SET: begin
              if (in_range) begin
                store_ctl_o.we = 1'b1;
                addr_o         = AddrWidth'(channel_i);
                dirty_d        = 1'b1;
              end
            end
            CMD_GET: begin
              store_ctl_o.re = in_range;
              addr_o         = AddrWidth'(channel_i);
              oob_d          = !in_range;
            end
            CMD_TICK: begin
              tick_d = (tick_inc >= period) ? '0 : tick_inc;
              if (boundary && dirty_q) begin
                // Start the frame at the highest channel
                store_ctl_o.re = 1'b1;
                addr_o         = LastIdx;
                dirty_d        = 1'b0;
                idx_d          = LastIdx;
                first_d        = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_GET: begin
        emit_o.load       = out_free_i;
        emit_o.kind       = KIND_READ;
        emit_o.zero_reply = oob_q;
      end
      ST_BLANK: begin
        emit_o.load  = out_free_i;
        emit_o.kind  = KIND_BLANK;
        emit_o.blank = 1'b1;
      end
      ST_STREAM: begin
        emit_o.load  = out_free_i;
        emit_o.kind  = KIND_GREY;
        emit_o.blank = first_q;
        emit_o.last  = (idx_q == '0);
        // Fetch the next lower channel as this word leaves
        if (out_free_i) begin
          first_d = 1'b0;
          if (idx_q != '0) begin
            store_ctl_o.re = 1'b1;
            addr_o         = idx_q - 1'b1;
            idx_d          = idx_q - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tick_q  <= '0;
      dirty_q <= 1'b0;
      idx_q   <= '0;
      first_q <= 1'b0;
      oob_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      tick_q  <= tick_d;
      dirty_q <= dirty_d;
      idx_q   <= idx_d;
      first_q <= first_d;
      oob_q   <= oob_d;
    end
  end

endmodule

@@ sv/led_greyscale_frame_feeder_top.sv @@
// A get reply is read into the store read register and then into the output register.
// Set stays in the idle state; get and a clean boundary tick each emit one word; a dirty frame
// tick emits NUM_CHANNELS words, one word per cycle from the store read port while the output
// register is free; output stalls hold the block, and in_ready_o is low while a command is at work.
// Reset (async, active low): frame period 20, tick counter and dirty mark cleared, and
// every channel reads back as duty 4095 until written; no clearing pass is needed.
module led_greyscale_frame_feeder_top #(
  parameter int unsigned NUM_CHANNELS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lgff_pkg::PeriodWidth-1:0] cfg_data_i,
  // command words
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [lgff_pkg::CmdWidth-1:0]    cmd_i,
  input  logic [lgff_pkg::ChanWidth-1:0]   channel_i,
  input  logic [lgff_pkg::WordWidth-1:0]   duty_i,
  // result words
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [lgff_pkg::KindWidth-1:0]   kind_o,
  output logic [lgff_pkg::WordWidth-1:0]   read_duty_o,
  output logic [lgff_pkg::WordWidth-1:0]   grey_word_o,
  output logic                             blank_pulse_o,
  output logic                             last_o
);
  import lgff_pkg::*;

  localparam int unsigned AddrWidth = $clog2(NUM_CHANNELS);

  logic [PeriodWidth-1:0] frame_period_q;
  logic                   out_valid_q;
  logic [KindWidth-1:0]   kind_q;
  logic [WordWidth-1:0]   read_duty_q;
  logic [WordWidth-1:0]   grey_word_q;
  logic                   blank_q;
  logic                   last_q;

  logic                   out_free;
  store_ctl_t             store_ctl;
  logic [AddrWidth-1:0]   store_addr;
  logic [WordWidth-1:0]   store_wdata;
  logic [WordWidth-1:0]   store_rdata;
  emit_t                  emit;

  // Frame period register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_period_q <= PeriodReset;
    end else if (cfg_valid_i) begin
      frame_period_q <= cfg_data_i;
    end
  end

  // Store the inverted duty for the active-low outputs
  assign store_wdata = FullScale - duty_i;

  lgff_store #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (store_ctl),
    .addr_i (store_addr),
    .wdata_i(store_wdata),
    .rdata_o(store_rdata)
  );

  lgff_ctrl #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .cmd_i         (cmd_i),
    .channel_i     (channel_i),
    .frame_period_i(frame_period_q),
    .out_free_i    (out_free),
    .in_ready_o    (in_ready_o),
    .store_ctl_o   (store_ctl),
    .addr_o        (store_addr),
    .emit_o        (emit)
  );

  // Output register: free when empty or being drained this cycle
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Format the result word
  always_ff @(posedge clk_i) begin
    if (emit.load) begin
      kind_q      <= emit.kind;
      blank_q     <= emit.blank;
      last_q      <= emit.last;
      read_duty_q <= ((emit.kind == KIND_READ) && !emit.zero_reply) ?
                     (FullScale - store_rdata) : '0;
      grey_word_q <= (emit.kind == KIND_GREY) ? store_rdata : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign read_duty_o   = read_duty_q;
  assign grey_word_o   = grey_word_q;
  assign blank_pulse_o = blank_q;
  assign last_o        = last_q;

endmodule

@@ bench/lgff_tb_pkg.sv @@
package lgff_tb_pkg;

  import lgff_pkg::*;

  localparam int unsigned NumChannels = 16;

  // Command code that the block has no use for
  localparam logic [CmdWidth-1:0] CmdUnused = 2'd3;

  // One result word as the block hands it out
  typedef struct packed {
    kind_e                kind;
    logic [WordWidth-1:0] read_duty;
    logic [WordWidth-1:0] grey_word;
    logic                 blank;
    logic                 last;
  } feeder_word_t;

  // Tracks the channel store, dirty mark and frame counter, and queues the words
  // that each accepted command should produce.
  class feeder_scoreboard;
    logic [WordWidth-1:0]   inv_duty [NumChannels];
    logic                   frame_dirty;
    logic [PeriodWidth-1:0] tick_cnt;
    logic [PeriodWidth-1:0] period;
    feeder_word_t           expected_q [$];
    int unsigned            errors;

    function new();
      foreach (inv_duty[i]) inv_duty[i] = '0;
      frame_dirty = 1'b0;
      tick_cnt    = '0;
      period      = PeriodReset;
      errors      = 0;
    endfunction

    function void set_period(logic [PeriodWidth-1:0] value);
      period = value;
    endfunction

    // Advance the store and counter for one accepted command word
    function void take_command(logic [CmdWidth-1:0] cmd, logic [ChanWidth-1:0] chan,
                               logic [WordWidth-1:0] duty);
      feeder_word_t           w;
      logic [PeriodWidth-1:0] span;
      w = '{kind: KIND_READ, read_duty: '0, grey_word: '0, blank: 1'b0, last: 1'b0};
      case (cmd)
        CMD_SET: begin
          if (chan < NumChannels) begin
            inv_duty[chan] = FullScale - duty;
            frame_dirty    = 1'b1;
          end
        end
        CMD_GET: begin
          if (chan < NumChannels) w.read_duty = FullScale - inv_duty[chan];
          expected_q.push_back(w);
        end
        CMD_TICK: begin
          span = (period == '0) ? PeriodWidth'(1) : period;
          if (tick_cnt == '0) begin
            if (frame_dirty) begin
              frame_dirty = 1'b0;
              w.kind = KIND_GREY;
              for (int i = 0; i < NumChannels; i++) begin
                w.grey_word = inv_duty[NumChannels-1-i];
                w.blank     = (i == 0);
                w.last      = (i == NumChannels - 1);
                expected_q.push_back(w);
              end
            end else begin
              w.kind  = KIND_BLANK;
              w.blank = 1'b1;
              expected_q.push_back(w);
            end
          end
          tick_cnt = tick_cnt + 1'b1;
          if (tick_cnt >= span) tick_cnt = '0;
        end
        default: ;
      endcase
    endfunction

    function void flag(string field, int unsigned want, int unsigned seen);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
    endfunction

    // Compare one accepted result word against the oldest expectation
    function void check_word(feeder_word_t got);
      feeder_word_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual kind %0d grey %0h read %0h",
                 $time, got.kind, got.grey_word, got.read_duty);
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind) flag("kind", want.kind, got.kind);
      if (got.read_duty !== want.read_duty) flag("read_duty", want.read_duty, got.read_duty);
      if (got.grey_word !== want.grey_word) flag("grey_word", want.grey_word, got.grey_word);
      if (got.blank !== want.blank) flag("blank_pulse", want.blank, got.blank);
      if (got.last !== want.last) flag("last", want.last, got.last);
    endfunction
  endclass

endpackage

@@ bench/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lgff_pkg::*;
  import lgff_tb_pkg::*;

  localparam int unsigned StallLimit   = 3000;
  localparam int unsigned SettleCycles = NumChannels + 8;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned PhaseWords   = 62;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [PeriodWidth-1:0] cfg_data_i  = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  logic [CmdWidth-1:0]    cmd_i       = '0;
  logic [ChanWidth-1:0]   channel_i   = '0;
  logic [WordWidth-1:0]   duty_i      = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [KindWidth-1:0]   kind_o;
  logic [WordWidth-1:0]   read_duty_o;
  logic [WordWidth-1:0]   grey_word_o;
  logic                   blank_pulse_o;
  logic                   last_o;

  feeder_scoreboard sb = new();

  bit          send_idle  = 1'b0;
  bit          recv_stall = 1'b0;
  bit          hold_req   = 1'b0;
  int unsigned idle_pct   = 58;
  int unsigned quiet_cycles = 0;

  led_greyscale_frame_feeder_top #(.NUM_CHANNELS(NumChannels)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .channel_i    (channel_i),
    .duty_i       (duty_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .read_duty_o  (read_duty_o),
    .grey_word_o  (grey_word_o),
    .blank_pulse_o(blank_pulse_o),
    .last_o       (last_o)
  );

  always #5ns clk_i = ~clk_i;

  // Check every result word taken at a clock edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_word(feeder_word_t'{kind: kind_e'(kind_o), read_duty: read_duty_o,
                                   grey_word: grey_word_o, blank: blank_pulse_o,
                                   last: last_o});
    end
  end

  // Abort when no channel moves a word for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Drive result ready: random stalls, plus one long hold when requested
  initial begin : receiver
    int unsigned n;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        for (n = 0; n < HoldCycles; n++) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i <= !(recv_stall && ($urandom_range(0, 99) < idle_pct));
    end
  end

  // Offer one command word and hold it until taken
  task automatic send_word(logic [CmdWidth-1:0] cmd, logic [ChanWidth-1:0] chan,
                           logic [WordWidth-1:0] duty);
    while (send_idle && ($urandom_range(0, 99) < idle_pct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    channel_i  <= chan;
    duty_i     <= duty;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_command(cmd, chan, duty);
  endtask

  // Drop valid, wait for every expected word, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_period(logic [PeriodWidth-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_period(value);
  endtask

  // Mixed commands; ticks dominate so frame boundaries come often at short periods
  task automatic send_random(int unsigned count);
    int unsigned          pick;
    logic [CmdWidth-1:0]  cmd;
    logic [ChanWidth-1:0] chan;
    logic [WordWidth-1:0] duty;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      chan = ChanWidth'($urandom_range(0, NumChannels - 1));
      if ($urandom_range(0, 7) == 0) begin
        duty = $urandom_range(0, 1) ? FullScale : '0;
      end else begin
        duty = WordWidth'($urandom_range(0, 4095));
      end
      if (pick < 35) cmd = CMD_SET;
      else if (pick < 55) cmd = CMD_GET;
      else if (pick < 95) cmd = CMD_TICK;
      else cmd = CmdUnused;
      send_word(cmd, chan, duty);
    end
  endtask

  initial begin : stimulus
    logic [PeriodWidth-1:0] periods [4];
    periods = '{10'd2, 10'd5, 10'd1, 10'd4};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset readback, first tick on a clean frame, unused command, edge duties
    send_word(CMD_GET, 4'd0, '0);
    send_word(CMD_GET, 4'd15, '0);
    send_word(CMD_TICK, 4'd0, '0);
    send_word(CmdUnused, 4'd9, 12'hFFF);
    send_word(CMD_SET, 4'd0, 12'h000);
    send_word(CMD_SET, 4'd15, 12'hFFF);
    send_word(CMD_SET, 4'd7, 12'hA5A);
    send_word(CMD_SET, 4'd8, 12'h5A5);
    send_word(CMD_GET, 4'd0, '0);
    send_word(CMD_GET, 4'd15, '0);
    send_word(CMD_GET, 4'd7, '0);
    send_word(CMD_TICK, 4'd3, '0);
    drain();

    // Zero period: the first tick returns the counter to zero, then each tick is a boundary on a dirty frame
    write_period('0);
    send_word(CMD_TICK, 4'd0, '0);
    send_word(CMD_TICK, 4'd0, '0);
    send_word(CMD_SET, 4'd3, 12'hFFF);
    send_word(CMD_TICK, 4'd0, '0);
    send_word(CmdUnused, 4'd15, 12'h000);
    drain();

    // Longest period, then lower it below the running count
    write_period('1);
    send_word(CMD_TICK, 4'd0, '0);
    send_word(CMD_TICK, 4'd0, '0);
    send_word(CMD_TICK, 4'd0, '0);
    drain();
    write_period(10'd1);
    send_word(CMD_TICK, 4'd0, '0);
    send_word(CMD_TICK, 4'd0, '0);
    drain();

    // Random phases: free flow with a long output hold, sender gaps, receiver stalls, both
    write_period(periods[0]);
    for (int phase = 0; phase < 4; phase++) begin
      send_idle  = (phase == 1) || (phase == 3);
      recv_stall = (phase == 2) || (phase == 3);
      idle_pct   = (phase == 3) ? 29 : 58;
      if (phase == 0) hold_req = 1'b1;
      send_random(PhaseWords);
      drain();
      if (phase < 3) write_period(periods[phase+1]);
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
